[design/ocgm_pkg.sv]
// shared types and constants of the ook carrier gate modulator
package ocgm_pkg;

  localparam int unsigned MaxSps   = 64;
  localparam int unsigned CntW     = $clog2(MaxSps);
  localparam int unsigned SpsW     = 7;
  localparam int unsigned AmpW     = 15;
  localparam int unsigned StepW    = 32;
  localparam int unsigned TabW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [AmpW-1:0] AmpReset = 15'd32767;
  localparam logic [SpsW-1:0] SpsReset = 7'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1,
    CFG_SPS        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic valid;
    logic data_bit;
  } queue_out_t;

endpackage

[design/ocgm_front.sv]
// input side: accepts bits and holds them in a short queue for the sample generator
module ocgm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                data_bit_i,
  input  logic                pop_i,
  output ocgm_pkg::queue_out_t head_o
);
  import ocgm_pkg::*;

  logic             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic             push;
  logic             pop;

  assign in_stall_o = (count_q == (QPtrW+1)'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid    = (count_q != '0);
  assign head_o.data_bit = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_bit_i;
    end
  end

endmodule

[design/ocgm_back.sv]
// sample side: config registers, symbol sequencer, phase accumulator and sine pipeline
module ocgm_back #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ocgm_pkg::cfg_wr_t      cfg_i,
  input  ocgm_pkg::queue_out_t   head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   last_of_symbol_o
);
  import ocgm_pkg::*;

  localparam int unsigned LgDepth = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DepthX2 = 2 * SINE_TABLE_DEPTH;
  localparam int unsigned Shift   = 31 - SAMPLE_BITS;
  localparam int unsigned ProdW   = AmpW + TabW;

  function automatic logic [TabW-1:0] sine_entry(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (64'd1686629713 * longint'(2 * i + 1)) / DepthX2;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
    return TabW'((64'd32767 * sum + (64'd1 << 29)) >> 30);
  endfunction

  logic [TabW-1:0] sine_tab [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
    assign sine_tab[g] = sine_entry(g);
  end

  // configuration registers
  logic [StepW-1:0] step_q;
  logic [AmpW-1:0]  amp_q;
  logic [SpsW-1:0]  sps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      amp_q  <= AmpReset;
      sps_q  <= SpsReset;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_PHASE_STEP: step_q <= cfg_i.data[StepW-1:0];
        CFG_AMPLITUDE:  amp_q  <= cfg_i.data[AmpW-1:0];
        CFG_SPS:        sps_q  <= cfg_i.data[SpsW-1:0];
        default: ;
      endcase
    end
  end

  // symbol sequencer
  logic                  en;
  logic                  issue;
  logic                  last;
  logic [CntW-1:0]       n_m1;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [1:0]            quad;
  logic [LgDepth-1:0]    idx;

  logic                  out_vld_q;

  assign en    = !out_vld_q || !out_stall_i;
  assign issue = head_i.valid && en;
  assign last  = (cnt_q == n_m1);
  assign pop_o = issue && last;

  always_comb begin
    if (sps_q == '0) begin
      n_m1 = '0;
    end else if (sps_q > SpsW'(MaxSps)) begin
      n_m1 = CntW'(MaxSps - 1);
    end else begin
      n_m1 = CntW'(sps_q - 1'b1);
    end
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (issue) begin
      cnt_d   = last ? '0 : cnt_q + 1'b1;
      phase_d = phase_q + PHASE_BITS'(step_q);
    end
  end

  assign quad = phase_q[PHASE_BITS-1 -: 2];
  assign idx  = phase_q[PHASE_BITS-3 -: LgDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  // sine pipeline
  logic                     s1_vld_q, s2_vld_q, s3_vld_q;
  logic                     s1_on_q;
  logic                     s1_neg_q, s2_neg_q, s3_neg_q;
  logic                     s1_last_q, s2_last_q, s3_last_q;
  logic [LgDepth-1:0]       s1_idx_q;
  logic [TabW-1:0]          s2_tab_q;
  logic [ProdW-1:0]         s3_prod_q;
  logic [ProdW:0]           rnd_sum;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic                     last_q;

  assign rnd_sum = {1'b0, s3_prod_q} + ((ProdW+1)'(1) << (Shift - 1));
  assign mag     = SAMPLE_BITS'(rnd_sum >> Shift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_on_q   <= head_i.data_bit;
      s1_neg_q  <= quad[1];
      s1_idx_q  <= quad[0] ? ~idx : idx;
      s1_last_q <= last;
      s2_tab_q  <= s1_on_q ? sine_tab[s1_idx_q] : '0;
      s2_neg_q  <= s1_neg_q;
      s2_last_q <= s1_last_q;
      s3_prod_q <= ProdW'(amp_q) * ProdW'(s2_tab_q);
      s3_neg_q  <= s2_neg_q;
      s3_last_q <= s2_last_q;
      sample_q  <= s3_neg_q ? (~mag + 1'b1) : mag;
      last_q    <= s3_last_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign sample_o         = sample_q;
  assign last_of_symbol_o = last_q;

endmodule

[design/ook_carrier_gate_modulator_core.sv]
// top level of the ook carrier gate modulator
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   data_bit_i
//   out      output     out_valid_o / out_stall_i sample_o, last_of_symbol_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one sample per cycle while not stalled; a bit gives as many samples as the symbol length
// (1 to 64), counted by the sequencer's sample counter; new bits queue up while a symbol plays
// a bit at the queue head passes s1, s2, s3 and the output register before its first sample
// reset clears queue, counters, phase; presets config; sine table: constant logic, no sweep
// out_stall_i with a valid output freezes the pipeline; the four-bit queue still fills
module ook_carrier_gate_modulator_core #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            data_bit_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   sample_o,
  output logic                            last_of_symbol_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ocgm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ocgm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ocgm_pkg::*;

  cfg_wr_t                cfg_wr;
  queue_out_t             head;
  logic                   pop;
  logic [SAMPLE_BITS-1:0] sample;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  ocgm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_bit_i (data_bit_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  ocgm_back #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_wr),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_o         (sample),
    .last_of_symbol_o (last_of_symbol_o)
  );

  assign sample_o = $signed(sample);

endmodule

[test/ook_carrier_gate_modulator_core_tb.sv]
// self-checking testbench for the ook carrier gate modulator core
module ook_carrier_gate_modulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ocgm_pkg::*;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned ReportCap  = 40;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct {
    logic signed [SampleW-1:0] level;
    logic                      last;
  } carrier_sample_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        data_bit_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [SampleW-1:0]   sample_o;
  logic                        last_of_symbol_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CfgIdxW-1:0]          cfg_index_i;
  logic [CfgDataW-1:0]         cfg_data_i;

  // own copy of the modulator state
  logic [StepW-1:0]            carrier_phase;
  logic [StepW-1:0]            step_reg;
  logic [AmpW-1:0]             amp_reg;
  logic [SpsW-1:0]             sps_reg;
  int                          quarter_sine [TableDepth];

  carrier_sample_t             pending_samples [$];
  int unsigned                 mismatches;
  int unsigned                 cycle_count;
  int unsigned                 stall_left;
  bit                          sender_gaps_on;
  bit                          stall_bursts_on;

  ook_carrier_gate_modulator_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_bit_i       (data_bit_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_o         (sample_o),
    .last_of_symbol_o (last_of_symbol_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL ook_carrier_gate_modulator_core");
      $finish;
    end
  end

  // output back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < ReportCap) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // quarter-wave sine in q1.15 from a q30 taylor series
  function automatic void build_quarter_sine();
    longint unsigned x, x2, term, acc;
    for (int i = 0; i < TableDepth; i++) begin
      x    = (64'd1686629713 * longint'(2 * i + 1)) / longint'(2 * TableDepth);
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 10; k++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      quarter_sine[i] = int'((64'd32767 * acc + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic logic signed [SampleW-1:0] carrier_level(input logic [StepW-1:0] ph);
    logic [1:0] quadrant;
    int         idx;
    longint     s, prod, mag, rounded;
    quadrant = ph[StepW-1 -: 2];
    idx      = int'(ph[StepW-3 -: 8]);
    if (quadrant[0]) idx = TableDepth - 1 - idx;
    s       = quadrant[1] ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
    prod    = longint'(amp_reg) * s;
    mag     = (prod < 0) ? -prod : prod;
    rounded = (mag + (64'sd1 << (30 - SampleW))) >>> (31 - SampleW);
    return (prod < 0) ? SampleW'(-rounded) : SampleW'(rounded);
  endfunction

  function automatic void predict_symbol(input logic bit_val);
    int              n;
    carrier_sample_t s;
    n = int'(sps_reg);
    if (n == 0) n = 1;
    if (n > MaxSps) n = MaxSps;
    for (int k = 0; k < n; k++) begin
      s.level = bit_val ? carrier_level(carrier_phase) : '0;
      s.last  = (k == n - 1);
      pending_samples = {pending_samples, s};
      carrier_phase = carrier_phase + step_reg;
    end
  endfunction

  always @(negedge clk_i) begin : check_samples
    carrier_sample_t want;
    if (rst_ni && $isunknown(out_valid_o)) report_mismatch("out_valid_o unknown");
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with nothing expected", sample_o));
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want.level)
          report_mismatch($sformatf("sample %0d, expected %0d", sample_o, want.level));
        if (last_of_symbol_o !== want.last)
          report_mismatch($sformatf("last_of_symbol %b, expected %b",
                                    last_of_symbol_o, want.last));
      end
    end
  end

  task automatic send_bit(input logic bit_val);
    bit accepted;
    cfg_valid_i <= 1'b0;
    if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_bit_i <= bit_val;
    do begin
      @(negedge clk_i);
      accepted = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end while (!accepted);
    predict_symbol(bit_val);
  endtask

  task automatic wait_drained();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    bit accepted;
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      accepted = (cfg_ready_o === 1'b1);
      @(posedge clk_i);
    end while (!accepted);
    case (idx)
      CFG_PHASE_STEP: step_reg = val[StepW-1:0];
      CFG_AMPLITUDE:  amp_reg  = val[AmpW-1:0];
      CFG_SPS:        sps_reg  = val[SpsW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_random_bits(input int count);
    for (int i = 0; i < count; i++) send_bit(1'($urandom_range(0, 1)));
  endtask

  task automatic test_default_config();
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
  endtask

  task automatic test_quadrants();
    wait_drained();
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    write_reg(CFG_AMPLITUDE, 32'd32767);
    write_reg(CFG_SPS, 32'd1);
    for (int i = 0; i < 4; i++) send_bit(1'b1);
    send_bit(1'b0);
  endtask

  task automatic test_amplitude_extremes();
    wait_drained();
    write_reg(CFG_AMPLITUDE, 32'd0);
    write_reg(CFG_SPS, 32'd64);
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    send_bit(1'b1);
    wait_drained();
    write_reg(CFG_AMPLITUDE, 32'd1);
    write_reg(CFG_SPS, 32'd2);
    write_reg(CFG_PHASE_STEP, 32'h0123_4567);
    send_bit(1'b1);
    send_bit(1'b1);
  endtask

  task automatic test_symbol_length_limits();
    // zero length acts as one, anything past 64 saturates
    wait_drained();
    write_reg(CFG_AMPLITUDE, 32'd20000);
    write_reg(CFG_SPS, 32'd0);
    send_bit(1'b1);
    send_bit(1'b0);
    wait_drained();
    write_reg(CFG_SPS, 32'd127);
    send_bit(1'b1);
    wait_drained();
    write_reg(CFG_SPS, 32'd65);
    send_bit(1'b0);
  endtask

  task automatic test_wide_writes();
    // bits above each register width are dropped
    wait_drained();
    write_reg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(CFG_SPS, 32'hFFFF_FF83);
    write_reg(CFG_PHASE_STEP, 32'h8000_0001);
    send_bit(1'b1);
    send_bit(1'b1);
  endtask

  task automatic test_unknown_index();
    wait_drained();
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    send_bit(1'b1);
    send_bit(1'b0);
  endtask

  task automatic configure_random();
    logic [CfgDataW-1:0] raw;
    logic [StepW-1:0]    step_val;
    logic [AmpW-1:0]     amp_val;
    logic [SpsW-1:0]     sps_val;
    case ($urandom_range(0, 4))
      0:       step_val = '0;
      1:       step_val = '1;
      2:       step_val = 32'h8000_0000;
      3:       step_val = $urandom_range(1, 32'h00FF_FFFF);
      default: step_val = $urandom();
    endcase
    case ($urandom_range(0, 4))
      0:       amp_val = '0;
      1:       amp_val = 15'd1;
      2:       amp_val = 15'd32767;
      default: amp_val = AmpW'($urandom_range(0, 32767));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0:       sps_val = '0;
        1:       sps_val = 7'd64;
        default: sps_val = SpsW'($urandom_range(65, 127));
      endcase
    end else begin
      sps_val = SpsW'($urandom_range(1, 16));
    end
    wait_drained();
    write_reg(CFG_PHASE_STEP, step_val);
    raw = $urandom();
    write_reg(CFG_AMPLITUDE, {raw[CfgDataW-1:AmpW], amp_val});
    raw = $urandom();
    write_reg(CFG_SPS, {raw[CfgDataW-1:SpsW], sps_val});
    if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, $urandom());
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      configure_random();
      sender_gaps_on  = ($urandom_range(0, 3) != 0);
      stall_bursts_on = ($urandom_range(0, 3) != 0);
      send_random_bits(26);
    end
  endtask

  task automatic test_drain_pause();
    configure_random();
    sender_gaps_on  = 1'b1;
    stall_bursts_on = 1'b1;
    send_random_bits(6);
    wait_drained();
    send_random_bits(6);
  endtask

  task automatic test_steady_stream();
    configure_random();
    sender_gaps_on  = 1'b0;
    stall_bursts_on = 1'b0;
    send_random_bits(20);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    data_bit_i      <= 1'b0;
    out_stall_i     <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    cycle_count     = 0;
    stall_left      = 0;
    mismatches      = 0;
    sender_gaps_on  = 1'b0;
    stall_bursts_on = 1'b0;
    build_quarter_sine();
    carrier_phase = '0;
    step_reg      = '0;
    amp_reg       = AmpReset;
    sps_reg       = SpsReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_config();
    test_quadrants();
    test_amplitude_extremes();
    test_symbol_length_limits();
    test_wide_writes();
    test_unknown_index();
    test_random_traffic();
    test_drain_pause();
    test_steady_stream();

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS ook_carrier_gate_modulator_core");
    end else begin
      $display("FAIL ook_carrier_gate_modulator_core");
    end
    $finish;
  end

endmodule

[sim.f]
design/ocgm_pkg.sv
design/ocgm_front.sv
design/ocgm_back.sv
design/ook_carrier_gate_modulator_core.sv
test/ook_carrier_gate_modulator_core_tb.sv
